// ----- design/sti_pkg.sv -----
// sti_pkg: shared widths, payload types and helpers for the segment/triangle unit
// no dependencies

package sti_pkg;

  localparam int CW         = 21;
  localparam int TF         = 16;
  localparam int EW         = CW + 1;
  localparam int PNW        = 2 * CW + 1;
  localparam int PDW        = 2 * CW;
  localparam int NW         = 2 * CW + 3;
  localparam int DIV_STAGES = TF + 1;
  localparam int PRW        = CW + TF + 2;
  localparam int MW         = PRW - TF;
  localparam int VW         = MW + 2;
  localparam int MLW        = 2 * EW;
  localparam int DOTW       = 2 * EW + 2;
  localparam int HW         = DOTW / 2;
  localparam int PLW        = DOTW + HW + 1;
  localparam int PHW        = DOTW + (DOTW - HW);
  localparam int WW         = 2 * DOTW + 4;
  localparam int LATENCY    = 12 + DIV_STAGES;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef logic [2:0][CW-1:0] vec_t;
  typedef logic [2:0][EW-1:0] evec_t;

  typedef struct packed {
    logic  ok;
    vec_t  s;
    vec_t  d;
    vec_t  a;
    evec_t e0;
    evec_t e1;
  } side_t;

  function automatic logic signed [EW-1:0] sub_ext(input logic [CW-1:0] x,
                                                  input logic [CW-1:0] y);
    sub_ext = $signed({x[CW-1], x}) - $signed({y[CW-1], y});
  endfunction

endpackage

// ----- design/sti_div.sv -----
// sti_div: pipelined restoring divider, one quotient bit per stage
// depends on sti_pkg

module sti_div import sti_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] den_i,
  input  side_t         side_i,
  output logic          out_valid_o,
  output logic [TF:0]   quot_o,
  output side_t         side_o
);

  logic          v_q   [DIV_STAGES];
  logic [NW-1:0] r_q   [DIV_STAGES];
  logic [NW-1:0] r_d   [DIV_STAGES];
  logic [NW-1:0] dn_q  [DIV_STAGES];
  logic [TF:0]   quo_q [DIV_STAGES];
  logic [TF:0]   quo_d [DIV_STAGES];
  side_t         sd_q  [DIV_STAGES];

  always_comb begin
    logic [NW-1:0] sh;
    logic [NW-1:0] dv;
    logic [TF:0]   qi;
    logic          ge;
    for (int i = 0; i < DIV_STAGES; i++) begin
      if (i == 0) begin
        sh = num_i;
        dv = den_i;
        qi = '0;
      end else begin
        sh = r_q[i-1] << 1;
        dv = dn_q[i-1];
        qi = quo_q[i-1];
      end
      ge       = (sh >= dv);
      r_d[i]   = ge ? sh - dv : sh;
      quo_d[i] = {qi[TF-1:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_STAGES; i++) v_q[i] <= 1'b0;
    end else begin
      v_q[0] <= in_valid_i;
      for (int i = 1; i < DIV_STAGES; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      r_q[i]   <= r_d[i];
      quo_q[i] <= quo_d[i];
    end
    dn_q[0] <= den_i;
    sd_q[0] <= side_i;
    for (int i = 1; i < DIV_STAGES; i++) begin
      dn_q[i] <= dn_q[i-1];
      sd_q[i] <= sd_q[i-1];
    end
  end

  assign out_valid_o = v_q[DIV_STAGES-1];
  assign quot_o      = quo_q[DIV_STAGES-1];
  assign side_o      = sd_q[DIV_STAGES-1];

endmodule

// ----- design/segment_triangle_intersect_unit.sv -----
// segment_triangle_intersect_unit: pipelined segment against triangle hit test
// depends on sti_pkg and sti_div
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  command  | start / busy       | seg_start_i seg_dir_i plane_normal_i
//           |                    | plane_point_i vert_a_i vert_b_i vert_c_i
//  result   | done_o (strobe)    | hit_o hit_point_o
//
// one transaction per cycle; busy stays low, the pipeline never stalls
// each result passes 2 setup stages, 17 divider stages for the plane parameter
// and 10 stages for the hit point and the barycentric test (LATENCY in sti_pkg)
// reset clears only the valid bits; results cannot be held off by the receiver

module segment_triangle_intersect_unit import sti_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic [3*CW-1:0] seg_start_i,
  input  logic [3*CW-1:0] seg_dir_i,
  input  logic [3*CW-1:0] plane_normal_i,
  input  logic [3*CW-1:0] plane_point_i,
  input  logic [3*CW-1:0] vert_a_i,
  input  logic [3*CW-1:0] vert_b_i,
  input  logic [3*CW-1:0] vert_c_i,
  output logic          done_o,
  output logic          hit_o,
  output logic [3*CW-1:0] hit_point_o
);

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  vec_t s_in, d_in, n_in, q_in, a_in, b_in, c_in;
  assign s_in = vec_t'(seg_start_i);
  assign d_in = vec_t'(seg_dir_i);
  assign n_in = vec_t'(plane_normal_i);
  assign q_in = vec_t'(plane_point_i);
  assign a_in = vec_t'(vert_a_i);
  assign b_in = vec_t'(vert_b_i);
  assign c_in = vec_t'(vert_c_i);

  // stage 1: plane products
  logic                  v1_q;
  logic signed [PNW-1:0] pn_d [3], pn_q [3];
  logic signed [PDW-1:0] pd_d [3], pd_q [3];
  side_t                 side1_d, side1_q;

  always_comb begin
    side1_d    = '0;
    side1_d.s  = s_in;
    side1_d.d  = d_in;
    side1_d.a  = a_in;
    for (int k = 0; k < 3; k++) begin
      pn_d[k]       = $signed(n_in[k]) * sub_ext(q_in[k], s_in[k]);
      pd_d[k]       = $signed(n_in[k]) * $signed(d_in[k]);
      side1_d.e0[k] = sub_ext(c_in[k], a_in[k]);
      side1_d.e1[k] = sub_ext(b_in[k], a_in[k]);
    end
  end

  // stage 2: sign normalize and range check of t
  logic                 v2_q;
  logic signed [NW-1:0] num_s, den_s, num_n, den_n;
  logic [NW-1:0]        num2_d, num2_q, den2_d, den2_q;
  side_t                side2_d, side2_q;

  always_comb begin
    num_s = NW'(pn_q[0]) + NW'(pn_q[1]) + NW'(pn_q[2]);
    den_s = NW'(pd_q[0]) + NW'(pd_q[1]) + NW'(pd_q[2]);
    if (den_s < 0) begin
      num_n = -num_s;
      den_n = -den_s;
    end else begin
      num_n = num_s;
      den_n = den_s;
    end
    side2_d    = side1_q;
    side2_d.ok = (den_s != 0) && !num_n[NW-1] && (num_n <= den_n);
    num2_d     = side2_d.ok ? num_n : '0;
    den2_d     = side2_d.ok ? den_n : NW'(1);
  end

  logic        v3;
  logic [TF:0] tq3;
  side_t       side3;

  sti_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v2_q),
    .num_i       (num2_q),
    .den_i       (den2_q),
    .side_i      (side2_q),
    .out_valid_o (v3),
    .quot_o      (tq3),
    .side_o      (side3)
  );

  // stage 4: direction times t
  logic                  v4_q;
  logic signed [PRW-1:0] prod4_d [3], prod4_q [3];
  side_t                 side4_q;

  always_comb begin
    for (int k = 0; k < 3; k++)
      prod4_d[k] = $signed(side3.d[k]) * $signed({1'b0, tq3});
  end

  // stage 5: rounded magnitude
  logic          v5_q;
  logic [MW-1:0] m5_d [3], m5_q [3];
  logic          neg5_q [3];
  side_t         side5_q;

  always_comb begin
    logic [PRW-1:0] mg;
    logic [PRW-1:0] rs;
    for (int k = 0; k < 3; k++) begin
      mg      = prod4_q[k][PRW-1] ? PRW'(-prod4_q[k]) : PRW'(prod4_q[k]);
      rs      = mg + (PRW'(1) << (TF - 1));
      m5_d[k] = rs[PRW-1:TF];
    end
  end

  // stage 6: hit point with saturation
  logic  v6_q;
  vec_t  p6_d, p6_q;
  side_t side6_q;

  always_comb begin
    logic signed [VW-1:0] off;
    logic signed [VW-1:0] v;
    for (int k = 0; k < 3; k++) begin
      off = neg5_q[k] ? -$signed({2'b0, m5_q[k]}) : $signed({2'b0, m5_q[k]});
      v   = VW'($signed(side5_q.s[k])) + off;
      if (v > VW'(CMAX))      p6_d[k] = CMAX;
      else if (v < VW'(CMIN)) p6_d[k] = CMIN;
      else                    p6_d[k] = v[CW-1:0];
    end
  end

  // stage 7: point relative to first vertex
  logic  v7_q;
  evec_t e2_d, e2_q;
  vec_t  p7_q;
  side_t side7_q;

  always_comb begin
    for (int k = 0; k < 3; k++) e2_d[k] = sub_ext(p6_q[k], side6_q.a[k]);
  end

  // stage 8: dot product terms (d00 d01 d02 d11 d12)
  logic                  v8_q, ok8_q;
  vec_t                  p8_q;
  logic signed [MLW-1:0] mul_d [5][3], mul_q [5][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mul_d[0][k] = $signed(side7_q.e0[k]) * $signed(side7_q.e0[k]);
      mul_d[1][k] = $signed(side7_q.e0[k]) * $signed(side7_q.e1[k]);
      mul_d[2][k] = $signed(side7_q.e0[k]) * $signed(e2_q[k]);
      mul_d[3][k] = $signed(side7_q.e1[k]) * $signed(side7_q.e1[k]);
      mul_d[4][k] = $signed(side7_q.e1[k]) * $signed(e2_q[k]);
    end
  end

  // stage 9: dot sums
  logic                   v9_q, ok9_q;
  vec_t                   p9_q;
  logic signed [DOTW-1:0] dot_d [5], dot_q [5];

  always_comb begin
    for (int j = 0; j < 5; j++)
      dot_d[j] = DOTW'(mul_q[j][0]) + DOTW'(mul_q[j][1]) + DOTW'(mul_q[j][2]);
  end

  // stage 10: split partial products of the wide terms
  logic                   v10_q, ok10_q;
  vec_t                   p10_q;
  logic signed [DOTW-1:0] xs [6], ys [6];
  logic signed [PLW-1:0]  pl_d [6], pl_q [6];
  logic signed [PHW-1:0]  ph_d [6], ph_q [6];

  always_comb begin
    xs[0] = dot_q[0]; ys[0] = dot_q[3];
    xs[1] = dot_q[1]; ys[1] = dot_q[1];
    xs[2] = dot_q[3]; ys[2] = dot_q[2];
    xs[3] = dot_q[1]; ys[3] = dot_q[4];
    xs[4] = dot_q[0]; ys[4] = dot_q[4];
    xs[5] = dot_q[1]; ys[5] = dot_q[2];
    for (int j = 0; j < 6; j++) begin
      pl_d[j] = xs[j] * $signed({1'b0, ys[j][HW-1:0]});
      ph_d[j] = xs[j] * $signed(ys[j][DOTW-1:HW]);
    end
  end

  // stage 11: full wide products
  logic                 v11_q, ok11_q;
  vec_t                 p11_q;
  logic signed [WW-1:0] full_d [6], full_q [6];

  always_comb begin
    for (int j = 0; j < 6; j++)
      full_d[j] = (WW'(ph_q[j]) <<< HW) + WW'(pl_q[j]);
  end

  // stage 12: barycentric numerators and denominator
  logic                 v12_q, ok12_q;
  vec_t                 p12_q;
  logic signed [WW-1:0] bden_q, un_q, vn_q;

  // stage 13: decision and result register
  logic                 done_q, hit_q;
  logic [3*CW-1:0]      hit_point_q;
  logic signed [WW-1:0] rest;
  logic                 hit_d;

  always_comb begin
    rest  = bden_q - un_q - vn_q;
    hit_d = ok12_q && (bden_q > 0) && !un_q[WW-1] && !vn_q[WW-1] && !rest[WW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      v8_q   <= 1'b0;
      v9_q   <= 1'b0;
      v10_q  <= 1'b0;
      v11_q  <= 1'b0;
      v12_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= accept;
      v2_q   <= v1_q;
      v4_q   <= v3;
      v5_q   <= v4_q;
      v6_q   <= v5_q;
      v7_q   <= v6_q;
      v8_q   <= v7_q;
      v9_q   <= v8_q;
      v10_q  <= v9_q;
      v11_q  <= v10_q;
      v12_q  <= v11_q;
      done_q <= v12_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pn_q    <= pn_d;
    pd_q    <= pd_d;
    side1_q <= side1_d;
    num2_q  <= num2_d;
    den2_q  <= den2_d;
    side2_q <= side2_d;
    prod4_q <= prod4_d;
    side4_q <= side3;
    m5_q    <= m5_d;
    for (int k = 0; k < 3; k++) neg5_q[k] <= prod4_q[k][PRW-1];
    side5_q <= side4_q;
    p6_q    <= p6_d;
    side6_q <= side5_q;
    e2_q    <= e2_d;
    p7_q    <= p6_q;
    side7_q <= side6_q;
    mul_q   <= mul_d;
    ok8_q   <= side7_q.ok;
    p8_q    <= p7_q;
    dot_q   <= dot_d;
    ok9_q   <= ok8_q;
    p9_q    <= p8_q;
    pl_q    <= pl_d;
    ph_q    <= ph_d;
    ok10_q  <= ok9_q;
    p10_q   <= p9_q;
    full_q  <= full_d;
    ok11_q  <= ok10_q;
    p11_q   <= p10_q;
    bden_q  <= full_q[0] - full_q[1];
    un_q    <= full_q[2] - full_q[3];
    vn_q    <= full_q[4] - full_q[5];
    ok12_q  <= ok11_q;
    p12_q   <= p11_q;
    hit_q   <= hit_d;
    hit_point_q <= hit_d ? p12_q : '0;
  end

  assign done_o      = done_q;
  assign hit_o       = hit_q;
  assign hit_point_o = hit_point_q;

endmodule

// ----- design/sti_checker.sv -----
// sti_checker: port-level assertions for segment_triangle_intersect_unit
// depends on sti_pkg; bound to the top level below

module sti_checker import sti_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input logic            hit_o,
  input logic [3*CW-1:0] hit_point_o
);

  // every accepted transaction returns after the fixed latency
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("result missing after accepted transaction");

  // no result without a matching transaction
  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result without transaction");

  // miss reports a zero point
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (hit_point_o == '0))
    else $error("nonzero point on miss");

  // fully pipelined, never busy
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

endmodule

bind segment_triangle_intersect_unit sti_checker u_sti_checker (.*);
